FILE: rtl/rss_pkg.sv
`default_nettype none

package rss_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 8;
	localparam int unsigned PC_W   = 6;
	localparam int unsigned POLY_W = 9;
	localparam int unsigned IDX_W  = 2;

	localparam logic [IDX_W-1:0] REG_MSG_LEN = 2'd0;
	localparam logic [IDX_W-1:0] REG_PAR_CNT = 2'd1;
	localparam logic [IDX_W-1:0] REG_POLY    = 2'd2;

	localparam logic [LEN_W-1:0]  MSG_LEN_RST = 8'd223;
	localparam logic [PC_W-1:0]   PAR_CNT_RST = 6'd32;
	localparam logic [POLY_W-1:0] POLY_RST    = 9'h11d;

	typedef struct packed {
		logic              start;
		logic [PC_W-1:0]   eff_p;
		logic [BYTE_W-1:0] poly_lo;
	} rss_ctl_t;

	function automatic logic [BYTE_W-1:0] gf_xtime(
		input logic [BYTE_W-1:0] a,
		input logic [BYTE_W-1:0] poly_lo
	);
		return {a[BYTE_W-2:0], 1'b0} ^ (a[BYTE_W-1] ? poly_lo : '0);
	endfunction

	function automatic logic [BYTE_W-1:0] gf_mul(
		input logic [BYTE_W-1:0] a,
		input logic [BYTE_W-1:0] b,
		input logic [BYTE_W-1:0] poly_lo
	);
		logic [BYTE_W-1:0] acc;
		logic [BYTE_W-1:0] x;
		acc = '0;
		x = a;
		for (int k = 0; k < BYTE_W; k++) begin
			if (b[k]) begin
				acc = acc ^ x;
			end
			x = gf_xtime(x, poly_lo);
		end
		return acc;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/rss_gen.sv
`default_nettype none

module rss_gen
	import rss_pkg::*;
#(
	parameter int unsigned MAX_PARITY = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire rss_ctl_t                            ctl,
	output logic                                     busy,
	output logic [MAX_PARITY-1:0][BYTE_W-1:0]        coeffs
);

	localparam logic [MAX_PARITY:0][BYTE_W-1:0] C_INIT = {{MAX_PARITY{8'd0}}, 8'd1};

	logic [MAX_PARITY:0][BYTE_W-1:0] c_q;
	logic [MAX_PARITY:0][BYTE_W-1:0] c_next;
	logic [BYTE_W-1:0]               root_q;
	logic [PC_W-1:0]                 step_q;
	logic                            busy_q;

	// multiply current product by (x + root): c[k] ^= c[k-1]*root
	always_comb begin
		c_next[0] = 8'd1;
		for (int k = 1; k <= MAX_PARITY; k++) begin
			c_next[k] = c_q[k] ^ gf_mul(c_q[k-1], root_q, ctl.poly_lo);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			step_q <= '0;
			root_q <= 8'd1;
			c_q    <= C_INIT;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			step_q <= '0;
			root_q <= 8'd1;
			c_q    <= C_INIT;
		end else if (busy_q) begin
			c_q    <= c_next;
			root_q <= gf_xtime(root_q, ctl.poly_lo);
			step_q <= step_q + 1'b1;
			if (step_q == ctl.eff_p - 1'b1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		for (int k = 0; k < MAX_PARITY; k++) begin
			coeffs[k] = c_q[k+1];
		end
	end

	assign busy = busy_q;

endmodule

`default_nettype wire

FILE: rtl/rss_div.sv
`default_nettype none

module rss_div
	import rss_pkg::*;
#(
	parameter int unsigned MAX_PARITY = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire rss_ctl_t                            ctl,
	input  wire logic [LEN_W-1:0]                    eff_len,
	input  wire logic                                accept,
	input  wire logic [BYTE_W-1:0]                   data_byte,
	input  wire logic [MAX_PARITY-1:0][BYTE_W-1:0]   coeffs,
	output logic                                     final_word,
	output logic [MAX_PARITY-1:0][BYTE_W-1:0]        rem_next
);

	logic [MAX_PARITY-1:0][BYTE_W-1:0] rem_q;
	logic [LEN_W-1:0]                  count_q;
	logic [LEN_W-1:0]                  count_inc;
	logic [BYTE_W-1:0]                 fb;

	assign fb        = data_byte ^ rem_q[0];
	assign count_inc = count_q + 1'b1;
	assign final_word = (count_inc == eff_len);

	always_comb begin
		for (int k = 0; k < MAX_PARITY; k++) begin
			rem_next[k] = gf_mul(coeffs[k], fb, ctl.poly_lo);
			if (k + 1 < MAX_PARITY) begin
				if ((PC_W+1)'(k + 1) < {1'b0, ctl.eff_p}) begin
					rem_next[k] = rem_next[k] ^ rem_q[(k + 1) % MAX_PARITY];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			count_q <= '0;
		end else if (ctl.start) begin
			rem_q   <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (final_word) begin
				rem_q   <= '0;
				count_q <= '0;
			end else begin
				rem_q   <= rem_next;
				count_q <= count_inc;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/reed_solomon_systematic_encoder_top.sv
// Systematic Reed-Solomon encoder over GF(256). Message bytes enter one per
// cycle on data_byte and come back unchanged on out_byte (is_parity low); the
// byte that completes a message of message_length bytes is followed by
// parity_count parity bytes (clamped to 1..MAX_PARITY), highest degree first,
// the final one with last high. Message bytes sustain one word per cycle while
// in_ready is high; after the final message byte, input is held off while the
// parity row drains through the single output register. The generator
// polynomial, product of (x + 2^i) for i = 0 .. parity_count-1 modulo
// field_polynomial, is built by one row of GF multipliers reused for every
// root, one root per cycle; input stays stalled until that row is done after
// reset and after every configuration write, which also restarts the codeword.
// Register indexes: 0 message_length, 1 parity_count, 2 field_polynomial;
// index 3 is ignored. A message_length of 0 acts as 1.
`default_nettype none

module reed_solomon_systematic_encoder_top
	import rss_pkg::*;
#(
	parameter int unsigned MAX_PARITY = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [POLY_W-1:0] cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [BYTE_W-1:0] data_byte,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [BYTE_W-1:0]      out_byte,
	output logic                   is_parity,
	output logic                   last
);

	localparam logic [PC_W-1:0] MAX_P = PC_W'(MAX_PARITY);

	logic [LEN_W-1:0]  msg_len_q;
	logic [PC_W-1:0]   par_cnt_q;
	logic [POLY_W-1:0] poly_q;
	logic [PC_W-1:0]   eff_p;
	logic [LEN_W-1:0]  eff_len;
	logic              cfg_wr;
	rss_ctl_t          ctl;

	logic                              gen_busy;
	logic [MAX_PARITY-1:0][BYTE_W-1:0] coeffs;
	logic                              final_word;
	logic [MAX_PARITY-1:0][BYTE_W-1:0] rem_next;

	logic [MAX_PARITY-1:0][BYTE_W-1:0] par_q;
	logic [PC_W-1:0]                   par_left_q;
	logic                              out_valid_q;
	logic [BYTE_W-1:0]                 out_byte_q;
	logic                              is_parity_q;
	logic                              last_q;
	logic                              in_acc;
	logic                              load_en;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && (cfg_index == REG_MSG_LEN || cfg_index == REG_PAR_CNT ||
		cfg_index == REG_POLY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_len_q <= MSG_LEN_RST;
			par_cnt_q <= PAR_CNT_RST;
			poly_q    <= POLY_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MSG_LEN: msg_len_q <= cfg_data[LEN_W-1:0];
				REG_PAR_CNT: par_cnt_q <= cfg_data[PC_W-1:0];
				REG_POLY:    poly_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (par_cnt_q == '0) begin
			eff_p = PC_W'(1);
		end else if (par_cnt_q > MAX_P) begin
			eff_p = MAX_P;
		end else begin
			eff_p = par_cnt_q;
		end
	end

	assign eff_len = (msg_len_q == '0) ? LEN_W'(1) : msg_len_q;

	assign ctl.start   = cfg_wr;
	assign ctl.eff_p   = eff_p;
	assign ctl.poly_lo = poly_q[BYTE_W-1:0];

	rss_gen #(
		.MAX_PARITY(MAX_PARITY)
	) u_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.busy   (gen_busy),
		.coeffs (coeffs)
	);

	rss_div #(
		.MAX_PARITY(MAX_PARITY)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.eff_len    (eff_len),
		.accept     (in_acc),
		.data_byte  (data_byte),
		.coeffs     (coeffs),
		.final_word (final_word),
		.rem_next   (rem_next)
	);

	assign load_en  = !out_valid_q || out_ready;
	assign in_ready = !gen_busy && (par_left_q == '0) && load_en;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			par_left_q  <= '0;
		end else if (load_en) begin
			if (par_left_q != '0) begin
				out_valid_q <= 1'b1;
				par_left_q  <= par_left_q - 1'b1;
			end else if (in_acc) begin
				out_valid_q <= 1'b1;
				if (final_word) begin
					par_left_q <= eff_p;
				end
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output word and parity row payload
	always_ff @(posedge clk) begin
		if (load_en) begin
			if (par_left_q != '0) begin
				out_byte_q  <= par_q[0];
				is_parity_q <= 1'b1;
				last_q      <= (par_left_q == PC_W'(1));
				for (int k = 0; k < MAX_PARITY - 1; k++) begin
					par_q[k] <= par_q[k+1];
				end
				par_q[MAX_PARITY-1] <= '0;
			end else if (in_acc) begin
				out_byte_q  <= data_byte;
				is_parity_q <= 1'b0;
				last_q      <= 1'b0;
				if (final_word) begin
					par_q <= rem_next;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign is_parity = is_parity_q;
	assign last      = last_q;

endmodule

`default_nettype wire
